// ===== hdl/http_message_framer_defines.svh =====
// ----------------------------------------------------------------------------
// HTTP message framer assertion macros
// Concurrent assertion wrappers; they are empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HTTP_MESSAGE_FRAMER_DEFINES_SVH
`define HTTP_MESSAGE_FRAMER_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define HMF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("http_message_framer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HMF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("http_message_framer: next-cycle check failed");

`else

`define HMF_ASSERT_SAME(label, ante, cons)
`define HMF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/hmf_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP message framer package
// Widths, character codes, parser state type and the keyword lookup.
// ----------------------------------------------------------------------------
package hmf_pkg;

	// Width of the internal byte counters and the length accumulator.
	localparam int CNT_W = 24;
	// Width of the length fields and of the size limit register.
	localparam int OUT_W = 24;
	localparam int MAX_W = 24;
	// Width used to compare a grown count against the size limit.
	localparam int CMP_W = (CNT_W + 1 > MAX_W) ? CNT_W + 1 : MAX_W;

	localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(1048576);

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UZ  = 8'h5A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam logic [3:0] KEY_LEN = 4'd15;

	// Progress through the CR LF CR LF header terminator.
	localparam logic [2:0] TP_NONE    = 3'd0;
	localparam logic [2:0] TP_CR      = 3'd1;
	localparam logic [2:0] TP_CRLF    = 3'd2;
	localparam logic [2:0] TP_CRLFCR  = 3'd3;

	localparam logic EV_FRAMED   = 1'b0;
	localparam logic EV_OVERFLOW = 1'b1;

	typedef enum logic [1:0] {
		PH_HEADER     = 2'd0,
		PH_VALUE      = 2'd1,
		PH_VALUE_DONE = 2'd2,
		PH_BODY       = 2'd3
	} hmf_phase_t;

	typedef struct packed {
		logic [2:0]       term_prog;
		logic [3:0]       key_prog;
		hmf_phase_t       phase;
		logic             len_seen;
		logic [CNT_W-1:0] len_acc;
		logic [CNT_W-1:0] hdr_cnt;
		logic [CNT_W-1:0] body_left;
		logic [CNT_W-1:0] msg_cnt;
	} hmf_state_t;

	typedef struct packed {
		logic             kind;
		logic [OUT_W-1:0] hdr_len;
		logic [OUT_W-1:0] body_len;
	} hmf_result_t;

	// Lower-case spelling of "content-length:".
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:  c = 8'h63;
			4'd1:  c = 8'h6F;
			4'd2:  c = 8'h6E;
			4'd3:  c = 8'h74;
			4'd4:  c = 8'h65;
			4'd5:  c = 8'h6E;
			4'd6:  c = 8'h74;
			4'd7:  c = 8'h2D;
			4'd8:  c = 8'h6C;
			4'd9:  c = 8'h65;
			4'd10: c = 8'h6E;
			4'd11: c = 8'h67;
			4'd12: c = 8'h74;
			4'd13: c = 8'h68;
			4'd14: c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/http_message_framer.sv =====
// The framer takes one byte of an HTTP stream per clock and, for each message,
// returns one transaction with the header length (through the final CR LF CR
// LF) and the Content-Length body length, or an overflow transaction with zero
// lengths when the message would exceed the size limit. It sustains one
// byte per cycle: the parser state register is updated once per byte by a
// single pass of next-state logic. The result for the byte that ends a
// message is registered and presented on the output, and it stays there
// until out_ready is high. While a result waits, the input register holds one
// more byte and then the input stalls. The size limit is written through
// cfg_wr_en and cfg_wr_data and should only change while the block is idle.
// ----------------------------------------------------------------------------
// HTTP message framer top level
// Input register, parser state, result register and size limit register.
// ----------------------------------------------------------------------------
`include "http_message_framer_defines.svh"

module http_message_framer import hmf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       data_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             event_kind,
	output logic [OUT_W-1:0] header_length,
	output logic [OUT_W-1:0] body_length,
	input  logic             cfg_wr_en,
	input  logic [MAX_W-1:0] cfg_wr_data
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	hmf_state_t       state_q;
	hmf_state_t       state_nxt;
	logic [MAX_W-1:0] max_q;
	logic             fire;
	hmf_result_t      res;
	hmf_result_t      res_s2;
	logic             valid_s2;
	logic             advance;

	// A byte moves through the parser whenever the result register can take it.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	hmf_step u_step (
		.cur     (state_q),
		.data    (byte_s1),
		.max_len (max_q),
		.nxt     (state_nxt),
		.fire    (fire),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
			max_q    <= MAX_RESET;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				state_q  <= state_nxt;
				valid_s2 <= fire;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
		if (advance && fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign event_kind    = res_s2.kind;
	assign header_length = res_s2.hdr_len;
	assign body_length   = res_s2.body_len;

	`HMF_ASSERT_SAME(a_overflow_zero_len, valid_s2 && res_s2.kind == EV_OVERFLOW, res_s2.hdr_len == '0 && res_s2.body_len == '0)
	`HMF_ASSERT_SAME(a_framed_has_term, valid_s2 && res_s2.kind == EV_FRAMED, res_s2.hdr_len >= OUT_W'(4))
	`HMF_ASSERT_SAME(a_body_left_nonzero, state_q.phase == PH_BODY, state_q.body_left != '0)
	`HMF_ASSERT_NEXT(a_stall_holds_byte, valid_s1 && valid_s2 && !out_ready, valid_s1 && $stable(byte_s1))

endmodule

// ===== hdl/hmf_step.sv =====
// ----------------------------------------------------------------------------
// HTTP message framer byte step
// Next parser state and optional result for one stream byte.
// ----------------------------------------------------------------------------
module hmf_step import hmf_pkg::*; (
	input  hmf_state_t       cur,
	input  logic [7:0]       data,
	input  logic [MAX_W-1:0] max_len,
	output hmf_state_t       nxt,
	output logic             fire,
	output hmf_result_t      res
);

	logic [CNT_W:0]   total;
	logic             too_long;
	logic [CNT_W-1:0] left_dec;
	logic [7:0]       lc;
	logic [3:0]       kp;
	logic [CNT_W+3:0] prod;
	logic             is_digit;
	logic             term_done;
	logic [CNT_W-1:0] acc_eff;

	assign total    = {1'b0, cur.msg_cnt} + (CNT_W+1)'(1);
	assign too_long = CMP_W'(total) > CMP_W'(max_len);
	assign left_dec = cur.body_left - CNT_W'(1);
	assign lc       = (data >= CH_UA && data <= CH_UZ) ? (data | CASE_BIT) : data;
	assign is_digit = data >= CH_0 && data <= CH_9;
	assign prod     = ({4'b0, cur.len_acc} << 3) + ({4'b0, cur.len_acc} << 1)
		+ (CNT_W+4)'(data[3:0]);

	always_comb begin
		if (cur.key_prog < KEY_LEN && lc == key_char(cur.key_prog)) begin
			kp = cur.key_prog + 4'd1;
		end else begin
			kp = (lc == key_char(4'd0)) ? 4'd1 : 4'd0;
		end
	end

	always_comb begin
		nxt       = cur;
		fire      = 1'b0;
		res       = '0;
		term_done = 1'b0;
		acc_eff   = '0;
		if (too_long) begin
			fire     = 1'b1;
			res.kind = EV_OVERFLOW;
			nxt      = '0;
		end else begin
			nxt.msg_cnt = total[CNT_W-1:0];
			if (cur.phase == PH_BODY) begin
				nxt.body_left = left_dec;
				if (left_dec == '0) begin
					fire         = 1'b1;
					res.kind     = EV_FRAMED;
					res.hdr_len  = OUT_W'(cur.hdr_cnt);
					res.body_len = OUT_W'(cur.len_acc);
					nxt          = '0;
				end
			end else begin
				nxt.hdr_cnt = cur.hdr_cnt + CNT_W'(1);

				if (cur.phase == PH_HEADER && !cur.len_seen) begin
					nxt.key_prog = kp;
					if (kp == KEY_LEN) begin
						nxt.len_seen = 1'b1;
						nxt.phase    = PH_VALUE;
					end
				end else if (cur.phase == PH_VALUE) begin
					if (is_digit) begin
						// Saturate once the value no longer fits the counter.
						nxt.len_acc = (prod[CNT_W+3:CNT_W] != 4'd0) ? '1 : prod[CNT_W-1:0];
					end else if (data != CH_SP && data != CH_TAB) begin
						nxt.phase = PH_VALUE_DONE;
					end
				end

				if (data == CH_CR) begin
					nxt.term_prog = (cur.term_prog == TP_CRLF) ? TP_CRLFCR : TP_CR;
				end else if (data == CH_LF) begin
					if (cur.term_prog == TP_CR) begin
						nxt.term_prog = TP_CRLF;
					end else if (cur.term_prog == TP_CRLFCR) begin
						term_done = 1'b1;
					end else begin
						nxt.term_prog = TP_NONE;
					end
				end else begin
					nxt.term_prog = TP_NONE;
				end

				if (term_done) begin
					nxt.term_prog = TP_NONE;
					acc_eff = nxt.len_seen ? nxt.len_acc : '0;
					if (acc_eff == '0) begin
						fire         = 1'b1;
						res.kind     = EV_FRAMED;
						res.hdr_len  = OUT_W'(nxt.hdr_cnt);
						res.body_len = '0;
						nxt          = '0;
					end else begin
						nxt.len_acc   = acc_eff;
						nxt.body_left = acc_eff;
						nxt.phase     = PH_BODY;
					end
				end
			end
		end
	end

endmodule
